@@ rtl/pda_pkg.sv @@
// Shared types and constants of the pairwise diversity accumulator.
package pda_pkg;

    // Field widths fixed by the interface.
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 8;
    localparam int OUT_W     = 48;
    localparam int MAX_ACC_W = 64;

    // Rows that the 6-bit index can reach, and the width of a triangle index over them.
    localparam int MAX_ROWS  = 64;
    localparam int TRI_W     = 12;

    // Width of one product term added into an accumulator.
    localparam int TERM_W    = 18;

    // Command codes on the mode port.
    localparam logic [1:0] MODE_ACC    = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Operations handed from the front to the back.
    typedef enum logic [1:0] {
        OP_ACC,
        OP_READ,
        OP_READ_NULL,
        OP_CLEAR
    } pda_kind_t;

    // One classified word waiting in the queue.
    typedef struct packed {
        pda_kind_t          kind;
        logic [IDX_W-1:0]   row;
        logic [TRI_W-1:0]   base;
        logic [CNT_W-1:0]   major;
        logic [CNT_W-1:0]   minor;
    } pda_op_t;

    // Head of the queue as the back sees it.
    typedef struct packed {
        logic    valid;
        pda_op_t op;
    } pda_qhead_t;

endpackage

@@ rtl/pairwise_diversity_accumulator_unit.sv @@
// Top level of the pairwise diversity accumulator.
//
//   Channel   Ports                                                  Handshake
//   command   mode individual partner major_count minor_count        taken when start & !busy
//   result    weight_sum difference_sum has_data                     one cycle, marked by done
//
// An accumulate of individual i holds the back for the pop, one pair-sum read-modify-write
// per earlier partner and for the self pair, and the drain of the pipeline.
// With the back idle, done rises after a read passes the read state; an out-of-range pair skips that state.
// A clear sweeps all NI*(NI+1)/2 pair-sum entries, with NI = min(NUM_INDIVIDUALS, 64).
// After reset the same sweep runs with busy high.
// A two-word queue takes commands while the back works; results are never held back.
module pairwise_diversity_accumulator_unit #(
    parameter int NUM_INDIVIDUALS = 64,
    parameter int ACC_WIDTH       = 48
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      mode,
    input  logic [pda_pkg::IDX_W-1:0]       individual,
    input  logic [pda_pkg::IDX_W-1:0]       partner,
    input  logic [pda_pkg::CNT_W-1:0]       major_count,
    input  logic [pda_pkg::CNT_W-1:0]       minor_count,
    output logic                            done,
    output logic [pda_pkg::OUT_W-1:0]       weight_sum,
    output logic [pda_pkg::OUT_W-1:0]       difference_sum,
    output logic                            has_data
);

    import pda_pkg::*;

    // Only rows the index field can reach need storage.
    localparam int ROWS       = (NUM_INDIVIDUALS < MAX_ROWS) ? NUM_INDIVIDUALS : MAX_ROWS;
    localparam int PAIR_DEPTH = (ROWS * (ROWS + 1)) / 2;

    logic        queue_full;
    logic        init_busy;
    logic        push;
    pda_op_t     push_op;
    logic        pop;
    pda_qhead_t  head;

    // Command decode and range checks.
    pda_front #(
        .NUM_INDIVIDUALS (NUM_INDIVIDUALS)
    ) u_front (
        .start       (start),
        .mode        (mode),
        .individual  (individual),
        .partner     (partner),
        .major_count (major_count),
        .minor_count (minor_count),
        .queue_full  (queue_full),
        .init_busy   (init_busy),
        .busy        (busy),
        .push        (push),
        .push_op     (push_op)
    );

    // Decoupling queue.
    pda_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .full    (queue_full)
    );

    // Accumulation engine.
    pda_back #(
        .CNT_DEPTH  (ROWS),
        .PAIR_DEPTH (PAIR_DEPTH),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .pop            (pop),
        .init_busy      (init_busy),
        .done           (done),
        .weight_sum     (weight_sum),
        .difference_sum (difference_sum),
        .has_data       (has_data)
    );

endmodule

@@ rtl/pda_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module pda_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/pda_front.sv @@
// Front part: accepts commands, checks ranges and builds the pair index.
module pda_front #(
    parameter int NUM_INDIVIDUALS = 64
) (
    input  logic                           start,
    input  logic [1:0]                     mode,
    input  logic [pda_pkg::IDX_W-1:0]      individual,
    input  logic [pda_pkg::IDX_W-1:0]      partner,
    input  logic [pda_pkg::CNT_W-1:0]      major_count,
    input  logic [pda_pkg::CNT_W-1:0]      minor_count,
    input  logic                           queue_full,
    input  logic                           init_busy,
    output logic                           busy,
    output logic                           push,
    output pda_pkg::pda_op_t               push_op
);

    import pda_pkg::*;

    // Row limit compared at a width that holds the largest individual count.
    localparam int          LIM_W   = 9;
    localparam logic [LIM_W-1:0] ROW_LIM = LIM_W'(NUM_INDIVIDUALS);

    logic                accept;
    logic [IDX_W-1:0]    row_r;
    logic [IDX_W-1:0]    col_r;
    logic                acc_ok;
    logic                read_ok;

    // Lower-triangle index of a pair: row*(row+1)/2 + col.
    function automatic logic [TRI_W-1:0] tri_index(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
        logic [TRI_W:0] prod;
        prod = {{(TRI_W+1-IDX_W){1'b0}}, row}
               * ({{(TRI_W+1-IDX_W){1'b0}}, row} + (TRI_W+1)'(1));
        return prod[TRI_W:1] + {{(TRI_W-IDX_W){1'b0}}, col};
    endfunction

    // The queue or the power-up sweep holds off new commands.
    assign busy   = queue_full | init_busy;
    assign accept = start & ~busy;

    // Pairs are unordered, so a read puts the larger index in the row.
    assign row_r   = (partner > individual) ? partner : individual;
    assign col_r   = (partner > individual) ? individual : partner;
    assign acc_ok  = ({{(LIM_W-IDX_W){1'b0}}, individual} < ROW_LIM);
    assign read_ok = ({{(LIM_W-IDX_W){1'b0}}, row_r} < ROW_LIM);

    // Classify the command into a queue word.
    always_comb
    begin
        push          = 1'b0;
        push_op.kind  = OP_ACC;
        push_op.row   = individual;
        push_op.base  = tri_index(individual, '0);
        push_op.major = major_count;
        push_op.minor = minor_count;
        case (mode)
            MODE_ACC:
            begin
                push = accept & acc_ok;
            end
            MODE_READ:
            begin
                push         = accept;
                push_op.kind = read_ok ? OP_READ : OP_READ_NULL;
                push_op.row  = row_r;
                push_op.base = tri_index(row_r, col_r);
            end
            MODE_CLEAR:
            begin
                push         = accept;
                push_op.kind = OP_CLEAR;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/pda_queue.sv @@
// Two-entry queue of classified words between the front and the back.
module pda_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pda_pkg::pda_op_t      push_op,
    input  logic                  pop,
    output pda_pkg::pda_qhead_t   head,
    output logic                  full
);

    import pda_pkg::*;

    pda_op_t     ent_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;

    assign head.valid = (cnt_reg != 2'd0);
    assign head.op    = ent_reg[rd_ptr_reg];
    assign full       = (cnt_reg == 2'd2);

    // Occupancy after this cycle's push and pop.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

@@ rtl/pda_back.sv @@
// Back part: walks the partners of a sample, reads and clears the pair sums.
module pda_back #(
    parameter int CNT_DEPTH  = 64,
    parameter int PAIR_DEPTH = 2080,
    parameter int ACC_WIDTH  = 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pda_pkg::pda_qhead_t          head,
    output logic                         pop,
    output logic                         init_busy,
    output logic                         done,
    output logic [pda_pkg::OUT_W-1:0]    weight_sum,
    output logic [pda_pkg::OUT_W-1:0]    difference_sum,
    output logic                         has_data
);

    import pda_pkg::*;

    localparam int CNT_AW  = $clog2(CNT_DEPTH);
    localparam int PAIR_AW = $clog2(PAIR_DEPTH);
    localparam logic [PAIR_AW-1:0] CLR_LAST = PAIR_AW'(PAIR_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_READ,
        ST_CLEAR
    } state_t;

    state_t                  state_reg;
    logic                    init_reg;
    logic [IDX_W-1:0]        j_reg;
    logic [PAIR_AW-1:0]      clr_reg;
    logic                    s1_valid_reg;
    logic                    s2_valid_reg;
    logic                    done_reg;

    logic [IDX_W-1:0]        me_reg;
    logic [TRI_W-1:0]        base_reg;
    logic [CNT_W-1:0]        maj_reg;
    logic [CNT_W-1:0]        min_reg;
    logic [IDX_W-1:0]        s1_j_reg;
    logic                    s1_self_reg;
    logic [PAIR_AW-1:0]      s2_addr_reg;
    logic [TERM_W-1:0]       s2_w_reg;
    logic [TERM_W-1:0]       s2_d_reg;
    logic [OUT_W-1:0]        wsum_reg;
    logic [OUT_W-1:0]        dsum_reg;
    logic                    has_reg;

    logic                    cnt_we;
    logic [2*CNT_W-1:0]      cnt_rdata;
    logic [CNT_W-1:0]        o_maj;
    logic [CNT_W-1:0]        o_min;
    logic [CNT_W:0]          cov;
    logic [CNT_W:0]          mult;
    logic [CNT_W-1:0]        fac_a;
    logic [CNT_W-1:0]        fac_b;
    logic [TERM_W-1:0]       w_term;
    logic [TERM_W-1:0]       d_term;
    logic [PAIR_AW-1:0]      walk_addr;

    logic                    acc_we;
    logic [PAIR_AW-1:0]      acc_waddr;
    logic [2*ACC_WIDTH-1:0]  acc_wdata;
    logic [PAIR_AW-1:0]      acc_raddr;
    logic [2*ACC_WIDTH-1:0]  acc_rdata;
    logic [ACC_WIDTH-1:0]    w_old;
    logic [ACC_WIDTH-1:0]    d_old;

    // Add a product term, sticking at the all-ones value.
    function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] acc,
                                                     input logic [TERM_W-1:0] term);
        logic [ACC_WIDTH:0] sum;
        sum = {1'b0, acc} + (ACC_WIDTH+1)'(term);
        return sum[ACC_WIDTH] ? '1 : sum[ACC_WIDTH-1:0];
    endfunction

    // Clamp an accumulator to the output field.
    function automatic logic [OUT_W-1:0] clamp_out(input logic [ACC_WIDTH-1:0] v);
        logic [MAX_ACC_W-1:0] wide;
        wide = MAX_ACC_W'(v);
        return (|wide[MAX_ACC_W-1:OUT_W]) ? '1 : wide[OUT_W-1:0];
    endfunction

    // Take the next word whenever the back is idle.
    assign pop       = (state_reg == ST_IDLE) & head.valid;
    assign init_busy = init_reg;
    assign cnt_we    = pop & (head.op.kind == OP_ACC);

    // Counts of the current locus, one entry per individual.
    pda_ram #(
        .WIDTH (2*CNT_W),
        .DEPTH (CNT_DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (head.op.row[CNT_AW-1:0]),
        .wdata ({head.op.major, head.op.minor}),
        .raddr (j_reg[CNT_AW-1:0]),
        .rdata (cnt_rdata)
    );

    // Product terms of the partner in stage one; the self term uses the sample's own counts.
    assign o_maj     = cnt_rdata[2*CNT_W-1:CNT_W];
    assign o_min     = cnt_rdata[CNT_W-1:0];
    assign cov       = {1'b0, maj_reg} + {1'b0, min_reg};
    assign mult      = s1_self_reg ? (cov - (CNT_W+1)'(1)) : ({1'b0, o_maj} + {1'b0, o_min});
    assign fac_a     = s1_self_reg ? min_reg : o_min;
    assign fac_b     = s1_self_reg ? maj_reg : o_maj;
    assign w_term    = TERM_W'(cov) * TERM_W'(mult);
    assign d_term    = TERM_W'(maj_reg) * TERM_W'(fac_a) + TERM_W'(fac_b) * TERM_W'(min_reg);
    assign walk_addr = PAIR_AW'(base_reg + {{(TRI_W-IDX_W){1'b0}}, s1_j_reg});

    // Accumulator port: walk writes first, then the clearing sweep.
    assign w_old     = acc_rdata[2*ACC_WIDTH-1:ACC_WIDTH];
    assign d_old     = acc_rdata[ACC_WIDTH-1:0];
    assign acc_raddr = s1_valid_reg ? walk_addr : PAIR_AW'(head.op.base);
    assign acc_we    = s2_valid_reg | (state_reg == ST_CLEAR);
    assign acc_waddr = s2_valid_reg ? s2_addr_reg : clr_reg;
    assign acc_wdata = s2_valid_reg ? {sat_add(w_old, s2_w_reg), sat_add(d_old, s2_d_reg)}
                                    : '0;

    // Weight and difference sums of every pair, kept side by side.
    pda_ram #(
        .WIDTH (2*ACC_WIDTH),
        .DEPTH (PAIR_DEPTH)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // Sequencer, pipeline valids and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            init_reg     <= 1'b1;
            j_reg        <= '0;
            clr_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg     <= 1'b0;
            s1_valid_reg <= (state_reg == ST_WALK);
            s2_valid_reg <= s1_valid_reg;
            case (state_reg)
                ST_IDLE:
                begin
                    if (head.valid)
                    begin
                        case (head.op.kind)
                            OP_ACC:
                            begin
                                j_reg     <= '0;
                                state_reg <= ST_WALK;
                            end
                            OP_READ:
                            begin
                                state_reg <= ST_READ;
                            end
                            OP_READ_NULL:
                            begin
                                done_reg <= 1'b1;
                            end
                            OP_CLEAR:
                            begin
                                clr_reg   <= '0;
                                state_reg <= ST_CLEAR;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_WALK:
                begin
                    j_reg <= j_reg + IDX_W'(1);
                    if (j_reg == me_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!s1_valid_reg && !s2_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_READ:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + PAIR_AW'(1);
                    if (clr_reg == CLR_LAST)
                    begin
                        init_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Sample operands, pipeline data and result fields.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            me_reg   <= head.op.row;
            base_reg <= head.op.base;
            maj_reg  <= head.op.major;
            min_reg  <= head.op.minor;
        end
        s1_j_reg    <= j_reg;
        s1_self_reg <= (j_reg == me_reg);
        s2_addr_reg <= walk_addr;
        s2_w_reg    <= w_term;
        s2_d_reg    <= d_term;
        if (state_reg == ST_READ)
        begin
            wsum_reg <= clamp_out(w_old);
            dsum_reg <= clamp_out(d_old);
            has_reg  <= (w_old != '0);
        end
        else if (pop && (head.op.kind == OP_READ_NULL))
        begin
            wsum_reg <= '0;
            dsum_reg <= '0;
            has_reg  <= 1'b0;
        end
    end

    assign done           = done_reg;
    assign weight_sum     = wsum_reg;
    assign difference_sum = dsum_reg;
    assign has_data       = has_reg;

`ifndef NO_ASSERTIONS
    // The pipeline is empty whenever a new word may be taken.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("pda_back: pipeline busy while idle");

    // A write-back stage always follows a product stage.
    a_s2_after_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> $past(s1_valid_reg))
        else $error("pda_back: write-back without product stage");

    // The clearing sweep never competes with a walk write.
    a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s2_valid_reg)
        else $error("pda_back: walk write during clearing sweep");

    // A strobe follows either a memory read or an out-of-range read.
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_READ || $past(state_reg) == ST_IDLE))
        else $error("pda_back: result strobe from wrong state");
`endif

endmodule
